// ===== hdl/mccp_pkg.sv =====
// Shared types, codes and constants of the motor CAN command packer.
`timescale 1ns / 1ps

package mccp_pkg;

    typedef enum logic [3:0] {
        OP_ENABLE        = 4'd0,
        OP_DISABLE       = 4'd1,
        OP_ZERO          = 4'd2,
        OP_CLEAR_ERROR   = 4'd3,
        OP_ANGLE_CORRECT = 4'd4,
        OP_READ          = 4'd5,
        OP_WRITE         = 4'd6,
        OP_IMPEDANCE     = 4'd7,
        OP_SPEED         = 4'd8,
        OP_POSITION      = 4'd9
    } opcode_t;

    localparam logic [7:0] SPECIAL_HEAD     = 8'h80;
    localparam logic [7:0] TAIL_ENABLE      = 8'hFC;
    localparam logic [7:0] TAIL_DISABLE     = 8'hFD;
    localparam logic [7:0] TAIL_ZERO        = 8'hFE;
    localparam logic [7:0] TAIL_CLEAR_ERROR = 8'hF4;
    localparam logic [7:0] TAIL_ANGLE_CORR  = 8'hF7;
    localparam logic [7:0] PARAM_TAIL       = 8'hEC;
    localparam logic [47:0] SPECIAL_FILL    = 48'hFFFF_FFFF_FFFF;

    localparam logic [16:0] POS_LIM = 17'd51200;
    localparam logic [16:0] VEL_LIM = 17'd57344;
    localparam logic [16:0] TRQ_LIM = 17'd51200;
    localparam logic [16:0] KP_MAX  = 17'd128000;
    localparam logic [14:0] KD_MAX  = 15'd25600;
    localparam logic [21:0] KI_MAX  = 22'd2560000;

    // command context carried alongside the arithmetic
    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  parameter_index;
        logic [31:0] parameter_bits;
    } ctx_t;

    // scaled values out of the arithmetic pipeline
    typedef struct packed {
        logic [14:0] pos_q;
        logic [11:0] vel_q;
        logic [11:0] kp_q;
        logic [11:0] kvp_q;
        logic [11:0] kd_q;
        logic [11:0] trq_q;
        logic [11:0] kvi_q;
        logic [15:0] kvp16_q;
        logic [15:0] kvi16_q;
        logic [14:0] vel_a;
        logic [2:0]  vel_r;
        logic [2:0]  vel_c;
    } scaled_t;

    // clamp a signed value to [-lim, lim] and offset it to [0, 2*lim]
    function automatic logic [16:0] clamp_offset(input logic signed [16:0] x,
                                                 input logic [16:0] lim);
        logic signed [17:0] xs;
        logic signed [17:0] ls;
        logic signed [17:0] sum;
        logic [16:0]        r;
        xs  = 18'(x);
        ls  = $signed({1'b0, lim});
        sum = xs + ls;
        if (xs < -ls)
            r = '0;
        else if (xs > ls)
            r = {lim[15:0], 1'b0};
        else
            r = sum[16:0];
        return r;
    endfunction

    // 31-bit velocity: a*2^17 + r*18724 + floor((4r - c)/7)
    function automatic logic [30:0] vel31_join(input logic [14:0] a,
                                               input logic [2:0] r,
                                               input logic [2:0] c);
        logic signed [5:0] v;
        logic signed [2:0] f;
        logic [31:0]       sum;
        v = $signed({1'b0, r, 2'b00}) - $signed({3'b000, c});
        if (v < 6'sd0)
            f = -3'sd1;
        else if (v >= 6'sd21)
            f = 3'sd3;
        else if (v >= 6'sd14)
            f = 3'sd2;
        else if (v >= 6'sd7)
            f = 3'sd1;
        else
            f = 3'sd0;
        sum = {a, 17'b0} + 32'(r) * 32'd18724 + 32'(f);
        return sum[30:0];
    endfunction

endpackage

// ===== hdl/mccp_scaler.sv =====
// Three-stage clamp and fixed-point scaling pipeline (offset, reciprocal estimate, correction).
`timescale 1ns / 1ps

module mccp_scaler
    import mccp_pkg::*;
(
    input  logic               clk,
    input  logic signed [16:0] target_position,
    input  logic signed [16:0] target_velocity,
    input  logic        [16:0] stiffness_gain,
    input  logic        [14:0] damping_gain,
    input  logic signed [16:0] feedforward_torque,
    input  logic        [16:0] speed_prop_gain,
    input  logic        [21:0] speed_int_gain,
    output scaled_t            scaled
);

    // stage 1: clamp, offset, multiply by 2^bits-1 and drop the power-of-two part of the span
    logic [16:0] pos_off, vel_off, trq_off, kp_c, kvp_c;
    logic [14:0] kd_c;
    logic [21:0] kvi_c;
    logic [31:0] pos_n;
    logic [28:0] vel_n, kp_n, kvp_n, trq_n;
    logic [26:0] kd_n;
    logic [33:0] kvi_n;
    logic [32:0] kvp16_n;
    logic [37:0] kvi16_n;
    logic [17:0] vel_ceil;

    logic [19:0] pos_m_next,   pos_m_reg;
    logic [14:0] vel_m_next,   vel_m_reg;
    logic [18:0] kp_m_next,    kp_m_reg;
    logic [18:0] kvp_m_next,   kvp_m_reg;
    logic [16:0] kd_m_next,    kd_m_reg;
    logic [16:0] trq_m_next,   trq_m_reg;
    logic [21:0] kvi_m_next,   kvi_m_reg;
    logic [22:0] kvp16_m_next, kvp16_m_reg;
    logic [25:0] kvi16_m_next, kvi16_m_reg;
    logic [16:0] vel_off_next, vel_off_reg;
    logic [2:0]  vel_c_next,   vel_c_reg;

    always_comb
    begin
        pos_off = clamp_offset(target_position, POS_LIM);
        vel_off = clamp_offset(target_velocity, VEL_LIM);
        trq_off = clamp_offset(feedforward_torque, TRQ_LIM);
        kp_c    = (stiffness_gain  > KP_MAX) ? KP_MAX : stiffness_gain;
        kvp_c   = (speed_prop_gain > KP_MAX) ? KP_MAX : speed_prop_gain;
        kd_c    = (damping_gain    > KD_MAX) ? KD_MAX : damping_gain;
        kvi_c   = (speed_int_gain  > KI_MAX) ? KI_MAX : speed_int_gain;

        pos_n   = {pos_off, 15'b0} - {15'b0, pos_off};
        vel_n   = {vel_off, 12'b0} - {12'b0, vel_off};
        kp_n    = {kp_c, 12'b0}    - {12'b0, kp_c};
        kvp_n   = {kvp_c, 12'b0}   - {12'b0, kvp_c};
        kd_n    = {kd_c, 12'b0}    - {12'b0, kd_c};
        trq_n   = {trq_off, 12'b0} - {12'b0, trq_off};
        kvi_n   = {kvi_c, 12'b0}   - {12'b0, kvi_c};
        kvp16_n = {kvp_c, 16'b0}   - {16'b0, kvp_c};
        kvi16_n = {kvi_c, 16'b0}   - {16'b0, kvi_c};
        vel_ceil = {1'b0, vel_off} + 18'd16383;

        pos_m_next   = pos_n[31:12];
        vel_m_next   = vel_n[28:14];
        kp_m_next    = kp_n[28:10];
        kvp_m_next   = kvp_n[28:10];
        kd_m_next    = kd_n[26:10];
        trq_m_next   = trq_n[28:12];
        kvi_m_next   = kvi_n[33:12];
        kvp16_m_next = kvp16_n[32:10];
        kvi16_m_next = kvi16_n[37:12];
        vel_off_next = vel_off;
        vel_c_next   = vel_ceil[16:14];
    end

    always_ff @(posedge clk)
    begin
        pos_m_reg   <= pos_m_next;
        vel_m_reg   <= vel_m_next;
        kp_m_reg    <= kp_m_next;
        kvp_m_reg   <= kvp_m_next;
        kd_m_reg    <= kd_m_next;
        trq_m_reg   <= trq_m_next;
        kvi_m_reg   <= kvi_m_next;
        kvp16_m_reg <= kvp16_m_next;
        kvi16_m_reg <= kvi16_m_next;
        vel_off_reg <= vel_off_next;
        vel_c_reg   <= vel_c_next;
    end

    // stage 2: quotient estimate by reciprocal, low by at most one
    logic [35:0] pos_p;
    logic [27:0] vel_p;
    logic [31:0] kp_p, kvp_p, vela_p;
    logic [29:0] kd_p, trq_p;
    logic [34:0] kvi_p;
    logic [39:0] kvp16_p;
    logic [42:0] kvi16_p;

    logic [14:0] pos_qe_next,   pos_qe_reg;
    logic [11:0] vel_qe_next,   vel_qe_reg;
    logic [11:0] kp_qe_next,    kp_qe_reg;
    logic [11:0] kvp_qe_next,   kvp_qe_reg;
    logic [11:0] kd_qe_next,    kd_qe_reg;
    logic [11:0] trq_qe_next,   trq_qe_reg;
    logic [11:0] kvi_qe_next,   kvi_qe_reg;
    logic [15:0] kvp16_qe_next, kvp16_qe_reg;
    logic [15:0] kvi16_qe_next, kvi16_qe_reg;
    logic [14:0] vela_qe_next,  vela_qe_reg;

    logic [19:0] pos_m2_reg;
    logic [14:0] vel_m2_reg;
    logic [18:0] kp_m2_reg, kvp_m2_reg;
    logic [16:0] kd_m2_reg, trq_m2_reg;
    logic [21:0] kvi_m2_reg;
    logic [22:0] kvp16_m2_reg;
    logic [25:0] kvi16_m2_reg;
    logic [16:0] vel_off2_reg;
    logic [2:0]  vel_c2_reg;

    always_comb
    begin
        pos_p   = pos_m_reg   * 36'd41943;
        vel_p   = vel_m_reg   * 28'd4681;
        kp_p    = kp_m_reg    * 32'd4194;
        kvp_p   = kvp_m_reg   * 32'd4194;
        kd_p    = kd_m_reg    * 30'd5242;
        trq_p   = trq_m_reg   * 30'd5242;
        kvi_p   = kvi_m_reg   * 35'd6710;
        kvp16_p = kvp16_m_reg * 40'd67108;
        kvi16_p = kvi16_m_reg * 43'd107374;
        vela_p  = vel_off_reg * 32'd18724;

        pos_qe_next   = pos_p[34:20];
        vel_qe_next   = vel_p[26:15];
        kp_qe_next    = kp_p[30:19];
        kvp_qe_next   = kvp_p[30:19];
        kd_qe_next    = kd_p[28:17];
        trq_qe_next   = trq_p[28:17];
        kvi_qe_next   = kvi_p[33:22];
        kvp16_qe_next = kvp16_p[38:23];
        kvi16_qe_next = kvi16_p[41:26];
        vela_qe_next  = vela_p[31:17];
    end

    always_ff @(posedge clk)
    begin
        pos_qe_reg   <= pos_qe_next;
        vel_qe_reg   <= vel_qe_next;
        kp_qe_reg    <= kp_qe_next;
        kvp_qe_reg   <= kvp_qe_next;
        kd_qe_reg    <= kd_qe_next;
        trq_qe_reg   <= trq_qe_next;
        kvi_qe_reg   <= kvi_qe_next;
        kvp16_qe_reg <= kvp16_qe_next;
        kvi16_qe_reg <= kvi16_qe_next;
        vela_qe_reg  <= vela_qe_next;
        pos_m2_reg   <= pos_m_reg;
        vel_m2_reg   <= vel_m_reg;
        kp_m2_reg    <= kp_m_reg;
        kvp_m2_reg   <= kvp_m_reg;
        kd_m2_reg    <= kd_m_reg;
        trq_m2_reg   <= trq_m_reg;
        kvi_m2_reg   <= kvi_m_reg;
        kvp16_m2_reg <= kvp16_m_reg;
        kvi16_m2_reg <= kvi16_m_reg;
        vel_off2_reg <= vel_off_reg;
        vel_c2_reg   <= vel_c_reg;
    end

    // stage 3: remainder check, bump the estimate where it fell short
    logic [19:0] pos_rem;
    logic [14:0] vel_rem;
    logic [18:0] kp_rem, kvp_rem;
    logic [16:0] kd_rem, trq_rem;
    logic [21:0] kvi_rem;
    logic [22:0] kvp16_rem;
    logic [25:0] kvi16_rem;
    logic [16:0] vela_rem;
    logic        vela_fix;

    scaled_t scaled_next, scaled_reg;

    always_comb
    begin
        pos_rem   = pos_m2_reg   - pos_qe_reg   * 20'd25;
        vel_rem   = vel_m2_reg   - vel_qe_reg   * 15'd7;
        kp_rem    = kp_m2_reg    - kp_qe_reg    * 19'd125;
        kvp_rem   = kvp_m2_reg   - kvp_qe_reg   * 19'd125;
        kd_rem    = kd_m2_reg    - kd_qe_reg    * 17'd25;
        trq_rem   = trq_m2_reg   - trq_qe_reg   * 17'd25;
        kvi_rem   = kvi_m2_reg   - kvi_qe_reg   * 22'd625;
        kvp16_rem = kvp16_m2_reg - kvp16_qe_reg * 23'd125;
        kvi16_rem = kvi16_m2_reg - kvi16_qe_reg * 26'd625;
        vela_rem  = vel_off2_reg - vela_qe_reg  * 17'd7;
        vela_fix  = (vela_rem >= 17'd7);

        scaled_next.pos_q   = pos_qe_reg   + 15'(pos_rem   >= 20'd25);
        scaled_next.vel_q   = vel_qe_reg   + 12'(vel_rem   >= 15'd7);
        scaled_next.kp_q    = kp_qe_reg    + 12'(kp_rem    >= 19'd125);
        scaled_next.kvp_q   = kvp_qe_reg   + 12'(kvp_rem   >= 19'd125);
        scaled_next.kd_q    = kd_qe_reg    + 12'(kd_rem    >= 17'd25);
        scaled_next.trq_q   = trq_qe_reg   + 12'(trq_rem   >= 17'd25);
        scaled_next.kvi_q   = kvi_qe_reg   + 12'(kvi_rem   >= 22'd625);
        scaled_next.kvp16_q = kvp16_qe_reg + 16'(kvp16_rem >= 23'd125);
        scaled_next.kvi16_q = kvi16_qe_reg + 16'(kvi16_rem >= 26'd625);
        scaled_next.vel_a   = vela_qe_reg  + 15'(vela_fix);
        scaled_next.vel_r   = vela_fix ? 3'(vela_rem - 17'd7) : vela_rem[2:0];
        scaled_next.vel_c   = vel_c2_reg;
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

// ===== hdl/motor_can_command_packer.sv =====
// Motor CAN command packer: command port, scaling pipeline, frame packing and output register.
// done is high for one cycle; a start transfer reaches it through s1/s2/s3 valid and done_reg.
// Throughput: one command per clock; busy stays low, the four register stages take a new one
// every cycle and valid bits travel with each command.
// Reset: rst_n clears the valid bits, done and transmit_id; commands in flight are dropped.
`timescale 1ns / 1ps

module motor_can_command_packer
    import mccp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_write,
    input  logic        [10:0] cfg_data,
    input  logic        [3:0]  opcode,
    input  logic signed [16:0] target_position,
    input  logic signed [16:0] target_velocity,
    input  logic        [16:0] stiffness_gain,
    input  logic        [14:0] damping_gain,
    input  logic signed [16:0] feedforward_torque,
    input  logic        [16:0] speed_prop_gain,
    input  logic        [21:0] speed_int_gain,
    input  logic        [7:0]  parameter_index,
    input  logic        [31:0] parameter_bits,
    output logic               done,
    output logic        [10:0] frame_id,
    output logic        [63:0] frame_payload,
    output logic               known_command
);

    logic [10:0] transmit_id_reg;
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        done_next, done_reg;
    logic        take;
    ctx_t        ctx_next, ctx1_reg, ctx2_reg, ctx3_reg;
    scaled_t     scaled;
    logic [30:0] vel31;
    logic [63:0] frame_payload_next, frame_payload_reg;
    logic        known_command_next, known_command_reg;
    logic [10:0] frame_id_reg;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transmit_id_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                transmit_id_reg <= cfg_data;
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= done_next;
        end
    end

    always_comb
    begin
        ctx_next.opcode          = opcode;
        ctx_next.parameter_index = parameter_index;
        ctx_next.parameter_bits  = parameter_bits;
    end

    always_ff @(posedge clk)
    begin
        ctx1_reg <= ctx_next;
        ctx2_reg <= ctx1_reg;
        ctx3_reg <= ctx2_reg;
    end

    mccp_scaler u_scaler (
        .clk                (clk),
        .target_position    (target_position),
        .target_velocity    (target_velocity),
        .stiffness_gain     (stiffness_gain),
        .damping_gain       (damping_gain),
        .feedforward_torque (feedforward_torque),
        .speed_prop_gain    (speed_prop_gain),
        .speed_int_gain     (speed_int_gain),
        .scaled             (scaled)
    );

    // stage 4: frame assembly
    always_comb
    begin
        vel31              = vel31_join(scaled.vel_a, scaled.vel_r, scaled.vel_c);
        done_next          = s3_valid_reg;
        frame_payload_next = '0;
        known_command_next = 1'b1;
        unique case (opcode_t'(ctx3_reg.opcode)) inside
            OP_ENABLE:
                frame_payload_next = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_ENABLE};
            OP_DISABLE:
                frame_payload_next = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_DISABLE};
            OP_ZERO:
                frame_payload_next = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_ZERO};
            OP_CLEAR_ERROR:
                frame_payload_next = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_CLEAR_ERROR};
            OP_ANGLE_CORRECT:
                frame_payload_next = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_ANGLE_CORR};
            OP_READ, OP_WRITE:
                frame_payload_next = {SPECIAL_HEAD,
                                      ctx3_reg.parameter_bits[7:0],
                                      ctx3_reg.parameter_bits[15:8],
                                      ctx3_reg.parameter_bits[23:16],
                                      ctx3_reg.parameter_bits[31:24],
                                      7'b0, (ctx3_reg.opcode == OP_WRITE),
                                      ctx3_reg.parameter_index,
                                      PARAM_TAIL};
            OP_IMPEDANCE:
                frame_payload_next = {1'b0, scaled.pos_q, scaled.vel_q, scaled.kp_q,
                                      scaled.kd_q, scaled.trq_q};
            OP_POSITION:
                frame_payload_next = {1'b0, scaled.pos_q, scaled.kvp_q, scaled.kp_q,
                                      scaled.kd_q, scaled.kvi_q};
            OP_SPEED:
                frame_payload_next = {1'b0, vel31, scaled.kvp16_q, scaled.kvi16_q};
            default:
                known_command_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        frame_payload_reg <= frame_payload_next;
        known_command_reg <= known_command_next;
        frame_id_reg      <= transmit_id_reg;
    end

    assign done          = done_reg;
    assign frame_id      = frame_id_reg;
    assign frame_payload = frame_payload_reg;
    assign known_command = known_command_reg;

endmodule

// ===== hdl/mccp_checker.sv =====
// Port-level checks of the motor CAN command packer and their binding to the top level.
`timescale 1ns / 1ps

module mccp_checker
    import mccp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic        [3:0]  opcode,
    input logic               done,
    input logic        [63:0] frame_payload,
    input logic               known_command
);

    // every transfer gives exactly one result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("command transfer without result four cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without matching command transfer");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (known_command == ($past(opcode, 4) <= OP_POSITION)))
        else $error("known_command does not match opcode");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !known_command) |-> (frame_payload == '0))
        else $error("unknown opcode gave a non-zero payload");

    a_special: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(opcode, 4) <= OP_ANGLE_CORRECT))
            |-> (frame_payload[63:8] == {SPECIAL_HEAD, SPECIAL_FILL}))
        else $error("special command frame head wrong");

endmodule

bind motor_can_command_packer mccp_checker u_mccp_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the motor CAN command packer: directed and random commands.
`timescale 1ns / 1ps

module testbench;
    import mccp_pkg::*;

    localparam int LATENCY         = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 144;

    localparam logic [3:0] FIRST_UNKNOWN_OP = 4'd10;
    localparam logic [3:0] LAST_OPCODE      = 4'd15;

    typedef struct {
        logic [3:0]  opcode;
        logic [16:0] position;
        logic [16:0] velocity;
        logic [16:0] kp;
        logic [14:0] kd;
        logic [16:0] torque;
        logic [16:0] kvp;
        logic [21:0] kvi;
        logic [7:0]  index;
        logic [31:0] bits;
    } command_t;

    typedef struct {
        logic [10:0] id;
        logic [63:0] payload;
        logic        known;
    } frame_t;

    class frame_scoreboard;
        logic [10:0] transmit_id;
        frame_t      expected_frames[$];
        int          errors;
        int          commands;
        int          unknown_commands;
        int          frames;

        function new();
            transmit_id      = '0;
            errors           = 0;
            commands         = 0;
            unknown_commands = 0;
            frames           = 0;
        endfunction

        // clamp to [-lim, lim] and shift to [0, 2*lim]
        function longint unsigned offset_signed(logic [16:0] raw, int lim);
            int v;
            v = $signed(raw);
            if (v < -lim)
                v = -lim;
            else if (v > lim)
                v = lim;
            return longint'(v + lim);
        endfunction

        function longint unsigned gain_clamp(longint unsigned v, longint unsigned lim);
            return (v > lim) ? lim : v;
        endfunction

        function longint unsigned scaled(longint unsigned off, longint unsigned span, int nbits);
            return off * ((64'd1 << nbits) - 64'd1) / span;
        endfunction

        function frame_t build_frame(command_t c);
            frame_t            f;
            longint unsigned   pos, vel, kp, kd, trq, kvp, kvi;
            longint unsigned   p, a, b, d, e;
            pos = offset_signed(c.position, int'(POS_LIM));
            vel = offset_signed(c.velocity, int'(VEL_LIM));
            trq = offset_signed(c.torque, int'(TRQ_LIM));
            kp  = gain_clamp(64'(c.kp), 64'(KP_MAX));
            kd  = gain_clamp(64'(c.kd), 64'(KD_MAX));
            kvp = gain_clamp(64'(c.kvp), 64'(KP_MAX));
            kvi = gain_clamp(64'(c.kvi), 64'(KI_MAX));
            f.id      = transmit_id;
            f.known   = 1'b1;
            f.payload = '0;
            case (c.opcode)
                OP_ENABLE:        f.payload = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_ENABLE};
                OP_DISABLE:       f.payload = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_DISABLE};
                OP_ZERO:          f.payload = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_ZERO};
                OP_CLEAR_ERROR:   f.payload = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_CLEAR_ERROR};
                OP_ANGLE_CORRECT: f.payload = {SPECIAL_HEAD, SPECIAL_FILL, TAIL_ANGLE_CORR};
                OP_READ, OP_WRITE:
                begin
                    f.payload = {SPECIAL_HEAD, c.bits[7:0], c.bits[15:8], c.bits[23:16],
                                 c.bits[31:24], 7'd0, (c.opcode == OP_WRITE), c.index,
                                 PARAM_TAIL};
                end
                OP_IMPEDANCE, OP_POSITION:
                begin
                    p = scaled(pos, 64'(POS_LIM) * 2, 15);
                    b = scaled(kp, 64'(KP_MAX), 12);
                    d = scaled(kd, 64'(KD_MAX), 12);
                    if (c.opcode == OP_IMPEDANCE)
                    begin
                        a = scaled(vel, 64'(VEL_LIM) * 2, 12);
                        e = scaled(trq, 64'(TRQ_LIM) * 2, 12);
                    end
                    else
                    begin
                        a = scaled(kvp, 64'(KP_MAX), 12);
                        e = scaled(kvi, 64'(KI_MAX), 12);
                    end
                    f.payload = {1'b0, p[14:0], a[11:0], b[11:0], d[11:0], e[11:0]};
                end
                OP_SPEED:
                begin
                    a = scaled(vel, 64'(VEL_LIM) * 2, 31);
                    b = scaled(kvp, 64'(KP_MAX), 16);
                    e = scaled(kvi, 64'(KI_MAX), 16);
                    f.payload = {1'b0, a[30:0], b[15:0], e[15:0]};
                end
                default: f.known = 1'b0;
            endcase
            return f;
        endfunction

        function void note_command(command_t c);
            expected_frames.push_back(build_frame(c));
            commands++;
            if (c.opcode > OP_POSITION)
                unknown_commands++;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_frame(logic [10:0] id, logic [63:0] payload, logic known);
            frame_t want;
            frames++;
            if (expected_frames.size() == 0)
            begin
                report_mismatch($sformatf("frame %h with no command outstanding", payload));
                return;
            end
            want = expected_frames.pop_front();
            if (id !== want.id)
                report_mismatch($sformatf("frame_id %h, expected %h", id, want.id));
            if (payload !== want.payload)
                report_mismatch($sformatf("frame_payload %h, expected %h", payload,
                                          want.payload));
            if (known !== want.known)
                report_mismatch($sformatf("known_command %b, expected %b", known, want.known));
        endtask

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_write;
    logic [10:0] cfg_data;
    logic [3:0]  opcode;
    logic [16:0] target_position;
    logic [16:0] target_velocity;
    logic [16:0] stiffness_gain;
    logic [14:0] damping_gain;
    logic [16:0] feedforward_torque;
    logic [16:0] speed_prop_gain;
    logic [21:0] speed_int_gain;
    logic [7:0]  parameter_index;
    logic [31:0] parameter_bits;
    logic        done;
    logic [10:0] frame_id;
    logic [63:0] frame_payload;
    logic        known_command;

    frame_scoreboard board;
    int              cycles = 0;
    int              id_settings = 0;

    motor_can_command_packer u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .cfg_write          (cfg_write),
        .cfg_data           (cfg_data),
        .opcode             (opcode),
        .target_position    (target_position),
        .target_velocity    (target_velocity),
        .stiffness_gain     (stiffness_gain),
        .damping_gain       (damping_gain),
        .feedforward_torque (feedforward_torque),
        .speed_prop_gain    (speed_prop_gain),
        .speed_int_gain     (speed_int_gain),
        .parameter_index    (parameter_index),
        .parameter_bits     (parameter_bits),
        .done               (done),
        .frame_id           (frame_id),
        .frame_payload      (frame_payload),
        .known_command      (known_command)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_frame(frame_id, frame_payload, known_command);
    end

    // mostly in range, some at or just past the ends, some anywhere in the field
    function automatic logic [31:0] pick_field(int lo, int hi, int wid);
        int unsigned mode;
        logic [31:0] v;
        logic [31:0] mask;
        mask = (wid >= 32) ? '1 : ((32'd1 << wid) - 32'd1);
        mode = $urandom_range(0, 9);
        if (mode < 7)
            v = lo + $urandom_range(0, hi - lo);
        else if (mode == 7)
        begin
            case ($urandom_range(0, 3))
                0:       v = lo;
                1:       v = hi;
                2:       v = lo - 1;
                default: v = hi + 1;
            endcase
        end
        else
            v = $urandom;
        return v & mask;
    endfunction

    function automatic command_t random_command();
        command_t c;
        if ($urandom_range(0, 9) == 0)
            c.opcode = 4'($urandom_range(FIRST_UNKNOWN_OP, LAST_OPCODE));
        else
            c.opcode = 4'($urandom_range(OP_ENABLE, OP_POSITION));
        c.position = 17'(pick_field(-int'(POS_LIM), int'(POS_LIM), 17));
        c.velocity = 17'(pick_field(-int'(VEL_LIM), int'(VEL_LIM), 17));
        c.kp       = 17'(pick_field(0, int'(KP_MAX), 17));
        c.kd       = 15'(pick_field(0, int'(KD_MAX), 15));
        c.torque   = 17'(pick_field(-int'(TRQ_LIM), int'(TRQ_LIM), 17));
        c.kvp      = 17'(pick_field(0, int'(KP_MAX), 17));
        c.kvi      = 22'(pick_field(0, int'(KI_MAX), 22));
        c.index    = 8'($urandom_range(0, 255));
        c.bits     = $urandom;
        return c;
    endfunction

    function automatic command_t make_command(logic [3:0] op, int pos, int vel, int kp, int kd,
                                              int trq, int kvp, int kvi, logic [7:0] idx,
                                              logic [31:0] raw);
        command_t c;
        c.opcode   = op;
        c.position = 17'(pos);
        c.velocity = 17'(vel);
        c.kp       = 17'(kp);
        c.kd       = 15'(kd);
        c.torque   = 17'(trq);
        c.kvp      = 17'(kvp);
        c.kvi      = 22'(kvi);
        c.index    = idx;
        c.bits     = raw;
        return c;
    endfunction

    task automatic drive_command(input command_t c);
        start              <= 1'b1;
        opcode             <= c.opcode;
        target_position    <= c.position;
        target_velocity    <= c.velocity;
        stiffness_gain     <= c.kp;
        damping_gain       <= c.kd;
        feedforward_torque <= c.torque;
        speed_prop_gain    <= c.kvp;
        speed_int_gain     <= c.kvi;
        parameter_index    <= c.index;
        parameter_bits     <= c.bits;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(c);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_transmit_id(input logic [10:0] id);
        cfg_data  <= id;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.transmit_id = id;
        id_settings++;
    endtask

    task automatic run_phase(input int count);
        int burst_left;
        burst_left = 0;
        for (int k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    burst_left = 40;
                else
                    burst_left = $urandom_range(1, 12);
                idle_gap($urandom_range(0, 6));
            end
            drive_command(random_command());
            burst_left--;
        end
    endtask

    task automatic run_directed();
        command_t c;
        for (int k = 0; k <= OP_ANGLE_CORRECT; k++)
        begin
            c        = random_command();
            c.opcode = 4'(k);
            drive_command(c);
        end
        drive_command(make_command(OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00, 32'h0000_0000));
        drive_command(make_command(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 32'hFFFF_FFFF));
        drive_command(make_command(OP_WRITE, 1, 1, 1, 1, 1, 1, 1, 8'hA5, 32'h3F80_1234));
        // impedance: lower ends, upper ends, past both ends, midscale
        drive_command(make_command(OP_IMPEDANCE, -51200, -57344, 0, 0, -51200, 0, 0, 0, 0));
        drive_command(make_command(OP_IMPEDANCE, 51200, 57344, 128000, 25600, 51200,
                                   128000, 2560000, 0, 0));
        drive_command(make_command(OP_IMPEDANCE, -65536, 65535, 131071, 32767, -65536,
                                   131071, 4194303, 0, 0));
        drive_command(make_command(OP_IMPEDANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // speed
        drive_command(make_command(OP_SPEED, 0, -57344, 0, 0, 0, 0, 0, 0, 0));
        drive_command(make_command(OP_SPEED, 0, 57344, 0, 0, 0, 128000, 2560000, 0, 0));
        drive_command(make_command(OP_SPEED, 0, 65535, 0, 0, 0, 131071, 4194303, 0, 0));
        drive_command(make_command(OP_SPEED, 0, -1, 0, 0, 0, 1, 1, 0, 0));
        // position
        drive_command(make_command(OP_POSITION, -51200, 0, 0, 0, 0, 0, 0, 0, 0));
        drive_command(make_command(OP_POSITION, 51200, 0, 128000, 25600, 0,
                                   128000, 2560000, 0, 0));
        drive_command(make_command(OP_POSITION, 65535, -65536, 131071, 32767, 65535,
                                   131071, 4194303, 0, 0));
        for (int k = 0; k <= LAST_OPCODE - FIRST_UNKNOWN_OP; k++)
            drive_command(make_command(4'(FIRST_UNKNOWN_OP + k), -1, -1, -1, -1, -1, -1, -1,
                                       8'hFF, 32'hFFFF_FFFF));
    endtask

    logic [10:0] phase_ids [PHASES];

    initial
    begin
        board = new();
        rst_n              <= 1'b0;
        start              <= 1'b0;
        cfg_write          <= 1'b0;
        cfg_data           <= '0;
        opcode             <= OP_ENABLE;
        target_position    <= '0;
        target_velocity    <= '0;
        stiffness_gain     <= '0;
        damping_gain       <= '0;
        feedforward_torque <= '0;
        speed_prop_gain    <= '0;
        speed_int_gain     <= '0;
        parameter_index    <= '0;
        parameter_bits     <= '0;
        phase_ids = '{11'h7FF, 11'h000, 11'h555, 11'h2AA, 11'($urandom_range(0, 2047)),
                      11'h400, 11'h001, 11'h7FF};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset value of transmit_id is checked by the directed part
        run_directed();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            set_transmit_id(phase_ids[ph]);
            run_phase(ITEMS_PER_PHASE);
        end
        wait_idle();
        repeat (LATENCY) @(posedge clk);

        $display("run covered %0d commands (%0d with unknown opcodes), %0d frames checked",
                 board.commands, board.unknown_commands, board.frames);
        $display("transmit_id settings: %0d, mismatches: %0d, outstanding: %0d",
                 id_settings, board.errors, board.pending());
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
